// File: sv/ftd_pkg.sv
// Shared types and constants for the FLV tag deframer.
`timescale 1ns / 1ps

package ftd_pkg;

  localparam logic [3:0]  HEADER_LAST  = 4'd14;
  localparam logic [3:0]  HDR_KIND     = 4'd4;
  localparam logic [3:0]  HDR_SIZE_LO  = 4'd5;
  localparam logic [3:0]  HDR_SIZE_HI  = 4'd7;
  localparam logic [3:0]  HDR_TIME_LO  = 4'd8;
  localparam logic [3:0]  HDR_TIME_HI  = 4'd10;
  localparam logic [7:0]  KIND_AUDIO   = 8'd8;
  localparam logic [7:0]  KIND_VIDEO   = 8'd9;
  localparam logic [3:0]  FRAME_KEY    = 4'd1;
  localparam logic [3:0]  CODEC_SKIP1  = 4'd4;
  localparam logic [3:0]  CODEC_SKIP4  = 4'd5;
  localparam logic [2:0]  SKIP_ONE     = 3'd1;
  localparam logic [2:0]  SKIP_FOUR    = 3'd4;
  localparam logic [13:0] TIME_SCALE   = 14'd10000;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [1:0] {
    PH_HEADER  = 2'd0,
    PH_FLAGS   = 2'd1,
    PH_SKIP    = 2'd2,
    PH_PAYLOAD = 2'd3
  } phase_t;

  typedef struct packed {
    logic        is_video;
    logic [23:0] tag_time;
    logic        sync_point;
    logic [7:0]  payload_byte;
    logic        byte_valid;
    logic        first_of_packet;
    logic        last_of_packet;
  } rec_t;

endpackage

// File: sv/flv_tag_deframer.sv
// Top level of the FLV tag deframer.
//
//   channel  | valid         | stall         | payload
//   ---------+---------------+---------------+-------------------------------------
//   stream   | stream_valid  | stream_stall  | stream_byte
//   packet   | packet_valid  | packet_stall  | is_video, start_time, sync_point,
//            |               |               | payload_byte, byte_valid,
//            |               |               | first_of_packet, last_of_packet
//
// One stream byte per cycle while stream_stall is low; a packet transaction passes
// through the queue write, then the timestamp multiply into the output register.
// The 4-entry record queue sets how long the packet side may stall before
// stream_stall rises. Synchronous reset returns the parser to the header
// phase and empties the queue and the output register.
`timescale 1ns / 1ps

module flv_tag_deframer (
  input  logic        clk,
  input  logic        rst,
  input  logic        stream_valid,
  output logic        stream_stall,
  input  logic [7:0]  stream_byte,
  output logic        packet_valid,
  input  logic        packet_stall,
  output logic        is_video,
  output logic [37:0] start_time,
  output logic        sync_point,
  output logic [7:0]  payload_byte,
  output logic        byte_valid,
  output logic        first_of_packet,
  output logic        last_of_packet
);
  import ftd_pkg::*;

  rec_t q_in;
  rec_t q_head;
  logic q_push;
  logic q_pop;
  logic q_empty;
  logic q_full;

  ftd_front u_front (
    .clk          (clk),
    .rst          (rst),
    .stream_valid (stream_valid),
    .stream_stall (stream_stall),
    .stream_byte  (stream_byte),
    .full         (q_full),
    .push         (q_push),
    .rec          (q_in)
  );

  ftd_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_rec (q_in),
    .pop      (q_pop),
    .head_rec (q_head),
    .empty    (q_empty),
    .full     (q_full)
  );

  ftd_back u_back (
    .clk             (clk),
    .rst             (rst),
    .empty           (q_empty),
    .head_rec        (q_head),
    .pop             (q_pop),
    .packet_valid    (packet_valid),
    .packet_stall    (packet_stall),
    .is_video        (is_video),
    .start_time      (start_time),
    .sync_point      (sync_point),
    .payload_byte    (payload_byte),
    .byte_valid      (byte_valid),
    .first_of_packet (first_of_packet),
    .last_of_packet  (last_of_packet)
  );

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    q_push |-> !q_full)
    else $error("record queue written while full");

  a_empty_marker: assert property (@(posedge clk) disable iff (rst)
    (packet_valid && !byte_valid) |-> (first_of_packet && last_of_packet &&
                                       payload_byte == 8'd0))
    else $error("empty packet marker malformed");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    q_pop |=> packet_valid)
    else $error("queue pop did not load the output register");

endmodule

// File: sv/ftd_front.sv
// Tag header parser: takes stream bytes and queues packet records.
`timescale 1ns / 1ps

module ftd_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          stream_valid,
  output logic          stream_stall,
  input  logic [7:0]    stream_byte,
  input  logic          full,
  output logic          push,
  output ftd_pkg::rec_t rec
);
  import ftd_pkg::*;

  phase_t      phase, phase_next;
  logic [3:0]  header_count, header_count_next;
  logic [7:0]  tag_kind, tag_kind_next;
  logic [23:0] payload_length, payload_length_next;
  logic [23:0] tag_time, tag_time_next;
  logic [23:0] bytes_left, bytes_left_next;
  logic [2:0]  skip_left, skip_left_next;
  logic        keyframe_flag, keyframe_flag_next;
  logic        first_pending, first_pending_next;

  logic        take;
  logic        av;
  logic        is_vid;
  logic        header_end;
  logic [23:0] bl_dec;
  logic [2:0]  sl_dec;
  logic [2:0]  codec_skip;
  logic [2:0]  skip_clamped;
  logic        new_key;

  assign stream_stall = full;
  assign take         = stream_valid && !full;
  assign is_vid       = (tag_kind == KIND_VIDEO);
  assign av           = (tag_kind == KIND_AUDIO) || is_vid;
  assign header_end   = (header_count >= HEADER_LAST);
  assign bl_dec       = bytes_left - 24'd1;
  assign sl_dec       = skip_left - 3'd1;
  assign new_key      = is_vid ? (stream_byte[7:4] == FRAME_KEY) : keyframe_flag;

  always_comb begin
    codec_skip = 3'd0;
    if (is_vid) begin
      if (stream_byte[3:0] == CODEC_SKIP1) codec_skip = SKIP_ONE;
      else if (stream_byte[3:0] == CODEC_SKIP4) codec_skip = SKIP_FOUR;
    end
    if ({21'd0, codec_skip} > bl_dec) skip_clamped = bl_dec[2:0];
    else skip_clamped = codec_skip;
  end

  always_comb begin
    phase_next = phase;
    if (take) begin
      case (phase)
        PH_HEADER: begin
          if (header_end) begin
            if (payload_length == 24'd0) phase_next = PH_HEADER;
            else if ((tag_kind == KIND_AUDIO) || (tag_kind == KIND_VIDEO))
              phase_next = PH_FLAGS;
            else phase_next = PH_PAYLOAD;
          end
        end
        PH_FLAGS: begin
          if (bl_dec == 24'd0) phase_next = PH_HEADER;
          else if (skip_clamped != 3'd0) phase_next = PH_SKIP;
          else phase_next = PH_PAYLOAD;
        end
        PH_SKIP: begin
          if (bl_dec == 24'd0) phase_next = PH_HEADER;
          else if (sl_dec == 3'd0) phase_next = PH_PAYLOAD;
        end
        PH_PAYLOAD: begin
          if (bl_dec == 24'd0) phase_next = PH_HEADER;
        end
        default: phase_next = PH_HEADER;
      endcase
    end
  end

  always_comb begin
    header_count_next   = header_count;
    tag_kind_next       = tag_kind;
    payload_length_next = payload_length;
    tag_time_next       = tag_time;
    bytes_left_next     = bytes_left;
    skip_left_next      = skip_left;
    keyframe_flag_next  = keyframe_flag;
    first_pending_next  = first_pending;
    push                = 1'b0;
    rec.is_video        = is_vid;
    rec.tag_time        = tag_time;
    rec.sync_point      = is_vid ? keyframe_flag : 1'b1;
    rec.payload_byte    = 8'd0;
    rec.byte_valid      = 1'b0;
    rec.first_of_packet = first_pending;
    rec.last_of_packet  = 1'b1;
    if (take) begin
      case (phase)
        PH_HEADER: begin
          if (header_count == HDR_KIND) tag_kind_next = stream_byte;
          else if (header_count >= HDR_SIZE_LO && header_count <= HDR_SIZE_HI)
            payload_length_next = {payload_length[15:0], stream_byte};
          else if (header_count >= HDR_TIME_LO && header_count <= HDR_TIME_HI)
            tag_time_next = {tag_time[15:0], stream_byte};
          if (header_end) begin
            header_count_next  = 4'd0;
            bytes_left_next    = payload_length;
            first_pending_next = 1'b1;
            keyframe_flag_next = 1'b0;
            skip_left_next     = 3'd0;
          end else begin
            header_count_next = header_count + 4'd1;
          end
        end
        PH_FLAGS: begin
          bytes_left_next    = bl_dec;
          keyframe_flag_next = new_key;
          skip_left_next     = skip_clamped;
          rec.sync_point     = is_vid ? new_key : 1'b1;
          if (bl_dec == 24'd0) begin
            push               = 1'b1;
            first_pending_next = 1'b0;
          end
        end
        PH_SKIP: begin
          bytes_left_next = bl_dec;
          skip_left_next  = sl_dec;
          if (bl_dec == 24'd0) begin
            push               = 1'b1;
            first_pending_next = 1'b0;
            skip_left_next     = 3'd0;
          end
        end
        PH_PAYLOAD: begin
          bytes_left_next    = bl_dec;
          rec.payload_byte   = stream_byte;
          rec.byte_valid     = 1'b1;
          rec.last_of_packet = (bl_dec == 24'd0);
          if (av) begin
            push               = 1'b1;
            first_pending_next = 1'b0;
          end
        end
        default: begin
          push = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_HEADER;
      header_count   <= 4'd0;
      tag_kind       <= 8'd0;
      payload_length <= 24'd0;
      tag_time       <= 24'd0;
      bytes_left     <= 24'd0;
      skip_left      <= 3'd0;
      keyframe_flag  <= 1'b0;
      first_pending  <= 1'b1;
    end else begin
      phase          <= phase_next;
      header_count   <= header_count_next;
      tag_kind       <= tag_kind_next;
      payload_length <= payload_length_next;
      tag_time       <= tag_time_next;
      bytes_left     <= bytes_left_next;
      skip_left      <= skip_left_next;
      keyframe_flag  <= keyframe_flag_next;
      first_pending  <= first_pending_next;
    end
  end

endmodule

// File: sv/ftd_queue.sv
// Short record queue between the header parser and the output stage.
`timescale 1ns / 1ps

module ftd_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  ftd_pkg::rec_t push_rec,
  input  logic          pop,
  output ftd_pkg::rec_t head_rec,
  output logic          empty,
  output logic          full
);
  import ftd_pkg::*;

  rec_t              mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              do_push;
  logic              do_pop;

  assign empty    = (count == QCNT_W'(0));
  assign full     = (count == QCNT_W'(QUEUE_DEPTH));
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign head_rec = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_rec;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr + QPTR_W'(1);
      if (do_pop) rd_ptr <= rd_ptr + QPTR_W'(1);
      if (do_push && !do_pop) count <= count + QCNT_W'(1);
      else if (do_pop && !do_push) count <= count - QCNT_W'(1);
    end
  end

endmodule

// File: sv/ftd_back.sv
// Output stage: scales the timestamp and holds the packet transaction.
`timescale 1ns / 1ps

module ftd_back (
  input  logic          clk,
  input  logic          rst,
  input  logic          empty,
  input  ftd_pkg::rec_t head_rec,
  output logic          pop,
  output logic          packet_valid,
  input  logic          packet_stall,
  output logic          is_video,
  output logic [37:0]   start_time,
  output logic          sync_point,
  output logic [7:0]    payload_byte,
  output logic          byte_valid,
  output logic          first_of_packet,
  output logic          last_of_packet
);
  import ftd_pkg::*;

  logic        load;
  logic [37:0] scaled;

  assign load   = !packet_valid || !packet_stall;
  assign pop    = load && !empty;
  assign scaled = 38'(head_rec.tag_time) * 38'(TIME_SCALE);

  always_ff @(posedge clk) begin
    if (rst) begin
      packet_valid <= 1'b0;
    end else if (load) begin
      packet_valid <= !empty;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      is_video        <= head_rec.is_video;
      start_time      <= scaled;
      sync_point      <= head_rec.sync_point;
      payload_byte    <= head_rec.payload_byte;
      byte_valid      <= head_rec.byte_valid;
      first_of_packet <= head_rec.first_of_packet;
      last_of_packet  <= head_rec.last_of_packet;
    end
  end

endmodule
